// ===== rtl/core/bat_pkg.sv =====
package bat_pkg;

   // window geometry
   localparam int WIN_DEPTH = 32;
   localparam int PTR_W     = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
   localparam int CNT_W     = $clog2(WIN_DEPTH + 1);

   // sample and ratio format
   localparam int EAR_W     = 16;
   localparam int RATIO_W   = 16;
   localparam int FRAC_BITS = 14;
   localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd12288;

   // datapath widths
   localparam int SUM_W  = EAR_W + CNT_W;
   localparam int LHS_W  = EAR_W + CNT_W;
   localparam int RHS_W  = SUM_W + RATIO_W;
   localparam int SHL_W  = LHS_W + FRAC_BITS;
   localparam int CMP_W  = (SHL_W > RHS_W) ? SHL_W : RHS_W;

   typedef logic [EAR_W-1:0] ear_type;
   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [SUM_W-1:0] sum_type;

endpackage

// ===== rtl/core/blink_adaptive_threshold.sv =====
// an accepted item is registered in stage 1, then stage 2, then stage 3, which drives rsp
// throughput: one item per cycle when not stalled; the window is a flop register
//   file with one read and one write at the ring pointer in the accept cycle
// back pressure stalls only the stages that are full, so bubbles are squeezed out
// reset (synchronous, active high) clears the fill count, ring pointer, running sum
//   and all valid flags, and sets ratio to 0.75; window entries are left as they are
module blink_adaptive_threshold (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [bat_pkg::EAR_W-1:0]    req_ear_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_closed,
   input  logic                         csr_wr_en,
   input  logic [bat_pkg::RATIO_W-1:0]  csr_ratio
);

   // ---------------------------------------------------------------
   // configuration register
   // ---------------------------------------------------------------
   logic [bat_pkg::RATIO_W-1:0] ratio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= bat_pkg::RATIO_RESET;
      end else if (csr_wr_en) begin
         ratio_ff <= csr_ratio;
      end
   end

   // ---------------------------------------------------------------
   // pipeline flow control: a stage takes an item when it is empty
   // or when its current item moves on in the same cycle
   // ---------------------------------------------------------------
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic rsp_valid_ff;
   logic s3_open;
   logic s2_open;
   logic s1_open;
   logic req_take;

   assign s3_open   = !rsp_valid_ff || rsp_ready;
   assign s2_open   = !s2_valid_ff || s3_open;
   assign s1_open   = !s1_valid_ff || s2_open;
   assign req_ready = s1_open;
   assign req_take  = req_valid && s1_open;

   // ---------------------------------------------------------------
   // window state: ring pointer, fill count, running sum
   // while filling, the ring pointer equals the fill count, so one
   // pointer serves both the append and the replace-oldest cases
   // ---------------------------------------------------------------
   bat_pkg::ear_type window_ff [bat_pkg::WIN_DEPTH];
   bat_pkg::ptr_type ptr_ff,  ptr_in;
   bat_pkg::cnt_type cnt_ff,  cnt_in;
   bat_pkg::sum_type sum_ff,  sum_in;
   bat_pkg::ear_type oldest;
   logic             full;

   assign full   = (cnt_ff == bat_pkg::CNT_W'(bat_pkg::WIN_DEPTH));
   assign oldest = window_ff[ptr_ff];

   always_comb begin
      ptr_in = (ptr_ff == bat_pkg::PTR_W'(bat_pkg::WIN_DEPTH - 1))
               ? '0 : ptr_ff + bat_pkg::PTR_W'(1);
      cnt_in = full ? cnt_ff : cnt_ff + bat_pkg::CNT_W'(1);
      // drop the oldest sample only once the window is full
      sum_in = sum_ff + bat_pkg::SUM_W'(req_ear_sample)
               - (full ? bat_pkg::SUM_W'(oldest) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         cnt_ff <= '0;
         sum_ff <= '0;
      end else if (req_take) begin
         ptr_ff <= ptr_in;
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         window_ff[ptr_ff] <= req_ear_sample;
      end
   end

   // ---------------------------------------------------------------
   // stage 1: snapshot of the sample and the updated count and sum
   // ---------------------------------------------------------------
   bat_pkg::ear_type s1_ear_ff;
   bat_pkg::cnt_type s1_cnt_ff;
   bat_pkg::sum_type s1_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_open) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ear_ff <= req_ear_sample;
         s1_cnt_ff <= cnt_in;
         s1_sum_ff <= sum_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: the two products, ear * count and sum * ratio
   // ---------------------------------------------------------------
   logic [bat_pkg::LHS_W-1:0] s2_lhs_ff, s2_lhs_in;
   logic [bat_pkg::RHS_W-1:0] s2_rhs_ff, s2_rhs_in;
   logic                      s1_move;

   assign s1_move   = s1_valid_ff && s2_open;
   assign s2_lhs_in = bat_pkg::LHS_W'(s1_ear_ff) * bat_pkg::LHS_W'(s1_cnt_ff);
   assign s2_rhs_in = bat_pkg::RHS_W'(s1_sum_ff) * bat_pkg::RHS_W'(ratio_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_open) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_lhs_ff <= s2_lhs_in;
         s2_rhs_ff <= s2_rhs_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 3: exact compare, ear * count * 2^14 < sum * ratio
   // ---------------------------------------------------------------
   logic [bat_pkg::CMP_W-1:0] cmp_lhs;
   logic [bat_pkg::CMP_W-1:0] cmp_rhs;
   logic                      rsp_closed_ff, rsp_closed_in;
   logic                      s2_move;

   assign s2_move       = s2_valid_ff && s3_open;
   assign cmp_lhs       = bat_pkg::CMP_W'({s2_lhs_ff, {bat_pkg::FRAC_BITS{1'b0}}});
   assign cmp_rhs       = bat_pkg::CMP_W'(s2_rhs_ff);
   assign rsp_closed_in = (cmp_lhs < cmp_rhs);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s3_open) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         rsp_closed_ff <= rsp_closed_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_closed = rsp_closed_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------

   // fill count never passes the window depth
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= bat_pkg::CNT_W'(bat_pkg::WIN_DEPTH))
      else $error("fill count above window depth");

   // while filling, the ring pointer tracks the fill count
   assert property (@(posedge clock) disable iff (reset)
      !full |-> (ptr_ff == bat_pkg::PTR_W'(cnt_ff)))
      else $error("ring pointer out of step with fill count");

   // an empty window holds a zero sum
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (sum_ff == '0))
      else $error("nonzero sum with empty window");

   // an accepted item always lands in stage 1
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted item lost at stage 1");

endmodule
